// ===== rtl/core/linear_probe_key_table_assert.svh =====
// Assertion macros for the key table; the clock is clk and the reset is rst_n.
`ifndef LINEAR_PROBE_KEY_TABLE_ASSERT_SVH
`define LINEAR_PROBE_KEY_TABLE_ASSERT_SVH
`ifndef ASSERT_OFF
`define LPKT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define LPKT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LPKT_ASSERT(lbl, prop, msg)
`define LPKT_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== rtl/core/lpkt_pkg.sv =====
`timescale 1ns / 1ps
package lpkt_pkg;

  localparam int unsigned TABLE_ENTRIES_DEF = 4096;
  localparam int unsigned KEY_BITS_DEF      = 32;
  localparam int unsigned IN_KEY_W          = 32;
  localparam int unsigned STATUS_W          = 3;
  localparam int unsigned SLOT_W            = 12;

  typedef enum logic [STATUS_W-1:0] {
    ST_FOUND    = 3'd0,
    ST_INSERTED = 3'd1,
    ST_ABSENT   = 3'd2,
    ST_NULL_KEY = 3'd3,
    ST_FULL     = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MUL,
    S_QM,
    S_SUB,
    S_START,
    S_PROBE,
    S_DONE
  } state_t;

endpackage

// ===== rtl/core/lpkt_if.sv =====
`timescale 1ns / 1ps
interface lpkt_req_if;
  import lpkt_pkg::*;
  logic                valid;
  logic                ready;
  logic [IN_KEY_W-1:0] lookup_key;
  logic                create_if_absent;
  modport source(output valid, lookup_key, create_if_absent, input ready);
  modport sink(input valid, lookup_key, create_if_absent, output ready);
endinterface

interface lpkt_rsp_if;
  import lpkt_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [SLOT_W-1:0]   slot_index;
  modport source(output valid, status, slot_index, input ready);
  modport sink(input valid, status, slot_index, output ready);
endinterface

// ===== rtl/core/linear_probe_key_table.sv =====
// Open-addressing key table with linear probing over one key memory with a
// read port and a write port. After reset the block runs a clearing pass that
// zeroes every slot and takes no request until it ends. A request is then
// accepted, its home slot is found by a reciprocal-multiply remainder unit
// that works on one 16-bit key digit per pass (multiply, quotient times
// modulus, subtract; skipped when TABLE_ENTRIES is a power of two), the first
// read is issued, slots are probed at one per cycle (the memory read port is
// the limit), and the result register is loaded. A result waits in its register
// while the next request is accepted. Keys are masked to KEY_BITS; slot_index
// carries the low 12 bits of the slot number.
`timescale 1ns / 1ps
`include "linear_probe_key_table_assert.svh"

module linear_probe_key_table #(
  parameter int unsigned TABLE_ENTRIES = lpkt_pkg::TABLE_ENTRIES_DEF,
  parameter int unsigned KEY_BITS      = lpkt_pkg::KEY_BITS_DEF
) (
  input logic        clk,
  input logic        rst_n,
  lpkt_req_if.sink   in_req,
  lpkt_rsp_if.source out_rsp
);
  import lpkt_pkg::*;

  localparam int unsigned AW    = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned RW    = AW + 1;
  localparam int unsigned DIG_W = 16;
  localparam int unsigned NDIG  = (KEY_BITS + DIG_W - 1) / DIG_W;
  localparam int unsigned DW    = NDIG * DIG_W;
  localparam int unsigned VW    = AW + DIG_W;
  localparam int unsigned QW    = DIG_W + 1;
  localparam int unsigned PW    = VW + QW;
  localparam int unsigned MW    = QW + RW;
  localparam int unsigned CW    = (NDIG > 1) ? $clog2(NDIG) : 1;
  localparam bit          POW2 = (TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0;
  localparam logic [AW-1:0] LAST    = AW'(TABLE_ENTRIES - 1);
  localparam logic [RW-1:0] MODULUS = RW'(TABLE_ENTRIES);
  // floor(2^VW / TABLE_ENTRIES); the quotient estimate is low by at most one
  localparam logic [QW-1:0] RECIP   = QW'((64'd1 << VW) / 64'(TABLE_ENTRIES));
  localparam logic [CW-1:0] CNT_END = CW'(NDIG - 1);

  logic [KEY_BITS-1:0] mem [TABLE_ENTRIES];

  state_t              state_r, state_nxt;
  logic [KEY_BITS-1:0] key_r;
  logic [DW-1:0]       div_r;
  logic                create_r;
  logic [AW-1:0]       rem_r;
  logic [QW-1:0]       quo_r;
  logic [VW-1:0]       qm_r;
  logic [CW-1:0]       cnt_r;
  logic [AW-1:0]       pos_r;
  logic [AW-1:0]       probes_r;
  logic [AW-1:0]       clr_r;
  logic [KEY_BITS-1:0] rd_data_r;
  status_t             status_r;
  logic [AW-1:0]       slot_r;
  logic                out_valid_r;
  status_t             out_status_r;
  logic [SLOT_W-1:0]   out_slot_r;

  logic [63:0]         key_wide;
  logic [63:0]         key_ext;
  logic [KEY_BITS-1:0] key_in;
  logic [AW-1:0]       home_direct;
  logic [VW-1:0]       mod_val, mod_diff;
  logic [PW-1:0]       mul_full;
  logic [MW-1:0]       qm_full;
  logic [RW-1:0]       mod_lo, mod_red;
  logic [AW-1:0]       pos_inc;
  logic                hit, empty, last_probe, accept, out_load;
  logic [AW-1:0]       rd_addr, wr_addr;
  logic                wr_en;
  logic [KEY_BITS-1:0] wr_data;
  logic [31:0]         slot_wide;

  assign key_wide    = {32'b0, in_req.lookup_key};
  assign key_in      = key_wide[KEY_BITS-1:0];
  assign key_ext     = 64'(key_in);
  assign home_direct = key_ext[AW-1:0];
  // one 16-bit digit per pass: remainder of {rem, digit} by reciprocal multiply
  assign mod_val     = {rem_r, div_r[DW-1 -: DIG_W]};
  assign mul_full    = PW'(mod_val) * PW'(RECIP);
  assign qm_full     = MW'(quo_r) * MW'(MODULUS);
  assign mod_diff    = mod_val - qm_r;
  assign mod_lo      = mod_diff[RW-1:0];
  assign mod_red     = (mod_lo >= MODULUS) ? (mod_lo - MODULUS) : mod_lo;
  assign pos_inc     = (pos_r == LAST) ? '0 : pos_r + 1'b1;
  assign hit         = rd_data_r == key_r;
  assign empty       = rd_data_r == '0;
  assign last_probe  = probes_r == LAST;
  assign accept      = in_req.valid && in_req.ready;
  assign out_load    = (state_r == S_DONE) && (!out_valid_r || out_rsp.ready);
  assign slot_wide   = 32'(slot_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: if (clr_r == LAST) state_nxt = S_IDLE;
      S_IDLE: begin
        if (accept) begin
          if (key_in == '0) state_nxt = S_DONE;
          else if (POW2)    state_nxt = S_START;
          else              state_nxt = S_MUL;
        end
      end
      S_MUL:   state_nxt = S_QM;
      S_QM:    state_nxt = S_SUB;
      S_SUB:   state_nxt = (cnt_r == CNT_END) ? S_START : S_MUL;
      S_START: state_nxt = S_PROBE;
      S_PROBE: if (hit || empty || last_probe) state_nxt = S_DONE;
      S_DONE:  if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_CLEAR;
    endcase
  end

  // outputs
  always_comb begin
    in_req.ready = 1'b0;
    rd_addr      = pos_r;
    wr_en        = 1'b0;
    wr_addr      = pos_r;
    wr_data      = key_r;
    unique case (state_r)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_r;
        wr_data = '0;
      end
      S_IDLE:  in_req.ready = 1'b1;
      S_START: rd_addr = pos_r;
      S_PROBE: begin
        rd_addr = pos_inc;
        wr_en   = !hit && empty && create_r;
      end
      S_MUL, S_QM, S_SUB, S_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) clr_r <= clr_r + 1'b1;
      if (out_load)           out_valid_r <= 1'b1;
      else if (out_rsp.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          key_r    <= key_in;
          div_r    <= DW'(key_in);
          create_r <= in_req.create_if_absent;
          rem_r    <= '0;
          cnt_r    <= '0;
          pos_r    <= home_direct;
          status_r <= ST_NULL_KEY;
          slot_r   <= '0;
        end
      end
      S_MUL: quo_r <= mul_full[VW +: QW];
      S_QM:  qm_r  <= qm_full[VW-1:0];
      S_SUB: begin
        rem_r <= mod_red[AW-1:0];
        div_r <= div_r << DIG_W;
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_END) pos_r <= mod_red[AW-1:0];
      end
      S_START: probes_r <= '0;
      S_PROBE: begin
        if (hit) begin
          status_r <= ST_FOUND;
          slot_r   <= pos_r;
        end else if (empty && create_r) begin
          status_r <= ST_INSERTED;
          slot_r   <= pos_r;
        end else if (empty || (last_probe && !create_r)) begin
          status_r <= ST_ABSENT;
          slot_r   <= '0;
        end else if (last_probe) begin
          status_r <= ST_FULL;
          slot_r   <= '0;
        end else begin
          pos_r    <= pos_inc;
          probes_r <= probes_r + 1'b1;
        end
      end
      S_DONE: begin
        if (out_load) begin
          out_status_r <= status_r;
          out_slot_r   <= slot_wide[SLOT_W-1:0];
        end
      end
      S_CLEAR: ;
      default: ;
    endcase
  end

  assign out_rsp.valid      = out_valid_r;
  assign out_rsp.status     = out_status_r;
  assign out_rsp.slot_index = out_slot_r;

  `LPKT_ASSERT(a_accept_leaves_idle, accept |=> state_r != S_IDLE, "accept did not start work")
  `LPKT_ASSERT(a_result_from_done, $rose(out_valid_r) |-> $past(state_r == S_DONE), "result loaded outside done")
  `LPKT_ASSERT(a_done_to_idle, out_load |=> state_r == S_IDLE, "done did not return to idle")
  `LPKT_ASSERT(a_pos_in_range, state_r == S_PROBE |-> pos_r <= LAST, "probe slot out of range")
  `LPKT_ASSERT_ALWAYS(a_reset_clears, !rst_n |=> state_r == S_CLEAR && !out_valid_r, "reset did not start clear")

endmodule

// ===== bench/key_table_checker.sv =====
`timescale 1ns / 1ps
module key_table_checker
  import lpkt_pkg::*;
#(
  parameter int unsigned SLOTS = TABLE_ENTRIES_DEF,
  parameter int unsigned KEY_W = KEY_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                req_valid,
  input  logic                req_ready,
  input  logic [IN_KEY_W-1:0] req_key,
  input  logic                req_create,
  input  logic                rsp_valid,
  input  logic                rsp_ready,
  input  logic [STATUS_W-1:0] rsp_status,
  input  logic [SLOT_W-1:0]   rsp_slot,
  output int                  fail_count,
  output int                  pending,
  output int                  found_count,
  output int                  inserted_count,
  output int                  absent_count,
  output int                  null_count,
  output int                  full_count
);

  typedef struct packed {
    status_t           status;
    logic [SLOT_W-1:0] slot;
  } lookup_result_t;

  logic [KEY_W-1:0] key_store [SLOTS];
  lookup_result_t   expected_results [$];

  task automatic report_mismatch(input string msg);
    fail_count++;
    if (fail_count <= 40) begin
      $display("[%0t] mismatch: %s", $time, msg);
    end
  endtask

  function automatic lookup_result_t predict_lookup(input logic [IN_KEY_W-1:0] raw_key,
                                                    input logic create);
    logic [KEY_W-1:0] key;
    int unsigned      pos;
    int unsigned      probes;
    bit               hit;
    bit               empty_seen;
    lookup_result_t   res;
    key = KEY_W'(raw_key);
    res = '{ST_NULL_KEY, '0};
    if (key == '0) begin
      return res;
    end
    pos        = 32'(64'(key) % 64'(SLOTS));
    probes     = 0;
    hit        = 1'b0;
    empty_seen = 1'b0;
    while (probes < SLOTS && !hit && !empty_seen) begin
      if (key_store[pos] == key) begin
        hit = 1'b1;
      end else if (key_store[pos] == '0) begin
        empty_seen = 1'b1;
      end else begin
        pos = (pos + 1 == SLOTS) ? 0 : pos + 1;
        probes++;
      end
    end
    if (hit) begin
      res = '{ST_FOUND, SLOT_W'(pos)};
    end else if (!create) begin
      res.status = ST_ABSENT;
    end else if (empty_seen) begin
      key_store[pos] = key;
      res = '{ST_INSERTED, SLOT_W'(pos)};
    end else begin
      res.status = ST_FULL;
    end
    return res;
  endfunction

  always @(posedge clk) begin
    lookup_result_t want;
    if (!rst_n) begin
      expected_results.delete();
      foreach (key_store[i]) key_store[i] = '0;
      fail_count     = 0;
      found_count    = 0;
      inserted_count = 0;
      absent_count   = 0;
      null_count     = 0;
      full_count     = 0;
    end else begin
      // results first, so a result never pairs with a lookup taken on the same edge
      if (rsp_valid && rsp_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result with no lookup outstanding: status %0d slot %0d",
                                    rsp_status, rsp_slot));
        end else begin
          want = expected_results.pop_front();
          if (rsp_status !== want.status) begin
            report_mismatch($sformatf("status expected %0d, got %0d", want.status, rsp_status));
          end
          if (rsp_slot !== want.slot) begin
            report_mismatch($sformatf("slot_index expected %0d, got %0d", want.slot, rsp_slot));
          end
          case (want.status)
            ST_FOUND:    found_count++;
            ST_INSERTED: inserted_count++;
            ST_ABSENT:   absent_count++;
            ST_NULL_KEY: null_count++;
            default:     full_count++;
          endcase
        end
      end
      if (req_valid && req_ready) begin
        expected_results.push_back(predict_lookup(req_key, req_create));
      end
    end
    pending = expected_results.size();
  end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
  import lpkt_pkg::*;

  localparam int unsigned SLOTS        = TABLE_ENTRIES_DEF;
  localparam int          RANDOM_ITEMS = 1750;
  localparam int          CYCLE_LIMIT  = 1_000_000;
  localparam int          HOLD_CYCLES  = 600;
  localparam int          HOLD_AT_ITEM = 400;
  localparam int          SYNC_AT_ITEM = 1200;
  localparam int          DRAIN_CYCLES = 64;

  logic clk;
  logic rst_n;

  lpkt_req_if in_req();
  lpkt_rsp_if out_rsp();

  int fail_count;
  int pending;
  int found_count;
  int inserted_count;
  int absent_count;
  int null_count;
  int full_count;

  int                  cycle_count = 0;
  int                  sent_count  = 0;
  bit                  calm        = 1'b0;
  bit                  hold_done   = 1'b0;
  int                  hold_left   = 0;
  logic [IN_KEY_W-1:0] sent_keys [$];

  linear_probe_key_table dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (in_req),
    .out_rsp(out_rsp)
  );

  key_table_checker table_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (in_req.valid),
    .req_ready     (in_req.ready),
    .req_key       (in_req.lookup_key),
    .req_create    (in_req.create_if_absent),
    .rsp_valid     (out_rsp.valid),
    .rsp_ready     (out_rsp.ready),
    .rsp_status    (out_rsp.status),
    .rsp_slot      (out_rsp.slot_index),
    .fail_count    (fail_count),
    .pending       (pending),
    .found_count   (found_count),
    .inserted_count(inserted_count),
    .absent_count  (absent_count),
    .null_count    (null_count),
    .full_count    (full_count)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_rsp.ready <= 1'b0;
    end else if (!hold_done && sent_count >= HOLD_AT_ITEM) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      out_rsp.ready <= 1'b0;
    end else begin
      out_rsp.ready <= calm || ($urandom_range(99) >= 34);
    end
  end

  task automatic send_lookup(input logic [IN_KEY_W-1:0] key, input logic create);
    while (!calm && $urandom_range(99) < 34) begin
      in_req.valid <= 1'b0;
      @(negedge clk);
    end
    in_req.valid            <= 1'b1;
    in_req.lookup_key       <= key;
    in_req.create_if_absent <= create;
    @(posedge clk);
    while (!in_req.ready) @(posedge clk);
    sent_count++;
    sent_keys.push_back(key);
    @(negedge clk);
  endtask

  initial begin
    logic [IN_KEY_W-1:0] key;
    int unsigned         pick;
    in_req.valid            = 1'b0;
    in_req.lookup_key       = '0;
    in_req.create_if_absent = 1'b0;
    out_rsp.ready           = 1'b0;
    rst_n                   = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_lookup(32'h0000_0000, 1'b1);
    send_lookup(32'h0000_0000, 1'b0);
    send_lookup(32'hFFFF_FFFF, 1'b0);
    send_lookup(32'hFFFF_FFFF, 1'b1);
    send_lookup(32'hFFFF_FFFF, 1'b0);
    // homes on the last slot: chain wraps to slot 0 and on
    send_lookup(32'h0000_0FFF, 1'b1);
    send_lookup(32'h0000_1FFF, 1'b1);
    send_lookup(32'h0000_1FFF, 1'b0);
    send_lookup(32'h0000_2FFF, 1'b0);
    send_lookup(32'h0000_0001, 1'b1);
    send_lookup(32'h8000_0000, 1'b1);
    send_lookup(32'h0000_0001, 1'b0);
    send_lookup(32'h0000_1000, 1'b0);
    send_lookup(32'h8000_0000, 1'b1);
    send_lookup(32'h1234_5678, 1'b1);
    send_lookup(32'h5555_5555, 1'b1);
    send_lookup(32'hAAAA_AAAA, 1'b1);
    send_lookup(32'h5555_5555, 1'b0);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      calm = (i >= 700 && i < 1000);
      if (i == SYNC_AT_ITEM) begin
        in_req.valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
      end
      pick = $urandom_range(99);
      if (pick < 4) begin
        key = '0;
      end else if (pick < 34) begin
        key = sent_keys[$urandom_range(sent_keys.size() - 1)];
      end else if (pick < 50) begin
        // crowd the homes around the table end for long, wrapping chains
        key = {20'($urandom()), 12'(($urandom_range(7) + SLOTS - 4) % SLOTS)};
      end else begin
        key = $urandom();
      end
      send_lookup(key, $urandom_range(99) < 60);
    end
    calm = 1'b0;

    send_lookup(32'hFFFF_FFFF, 1'b1);
    send_lookup(32'h0000_0000, 1'b1);
    send_lookup(32'h8000_0000, 1'b0);

    in_req.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Checked %0d lookups: %0d found, %0d inserted, %0d absent, %0d null key, %0d full.",
             sent_count, found_count, inserted_count, absent_count, null_count, full_count);
    $display("Chains wrapped past the last slot, output held off %0d cycles, input drained once.",
             HOLD_CYCLES);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/lpkt_pkg.sv
rtl/core/lpkt_if.sv
rtl/core/linear_probe_key_table.sv
bench/key_table_checker.sv
bench/testbench.sv
